### design/window_median_filter_defines.svh
// Assertion macros shared by the window median filter RTL.
// Every macro expects signals named clk and arst_n in the including scope.
`ifndef WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define WINDOW_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WMF_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WMF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/wmf_pkg.sv
// Shared types and fixed constants of the window median filter.
// No dependencies; the filter modules import this package.
`timescale 1ns / 1ps
`default_nettype none

package wmf_pkg;

	// Sample and register widths fixed by the block's interface.
	localparam int PIX_W      = 16;
	localparam int ROW_CNT_W  = 13;
	localparam int ROW_IDX_W  = 12;
	localparam int MAX_ROWS   = 4096;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int ROWS_CFG_W = 13;
	localparam int COLS_CFG_W = 11;
	localparam int RAD_CFG_W  = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_ROWS    = 2'd0,
		REG_FRAME_COLS    = 2'd1,
		REG_WINDOW_RADIUS = 2'd2
	} cfg_reg_t;

	// Kind of an input request.
	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_FLUSH = 1'b1
	} action_t;

	// Input request payload.
	typedef struct packed {
		action_t          action;
		logic [PIX_W-1:0] pixel_value;
	} pix_req_t;

	// Result payload.
	typedef struct packed {
		logic [PIX_W-1:0] median_value;
		logic             frame_end;
	} med_rsp_t;

	// Per-request decision of the position sequencer.
	typedef struct packed {
		logic emit;
		logic frame_end;
	} item_info_t;

endpackage

`default_nettype wire

### design/wmf_stream_if.sv
// Valid/ready stream interface carrying one payload of a given type.
// Independent of the package; the payload type is set per instance.
`timescale 1ns / 1ps
`default_nettype none

interface wmf_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/window_median_filter.sv
// Throughput: one request per cycle unless back-pressure from the result side stalls
// the input; every line store bank is read once per request, one bank is written per
// stored pixel, and rank compare and median select are separate pipeline stages.
// Reset clears counters and valid flags and sets registers (rows 1, columns 1,
// radius 1); line store contents stay undefined until written, with no clearing pass.
// Top level of the window median filter; uses wmf_pkg, wmf_stream_if and submodules.
`timescale 1ns / 1ps
`default_nettype none

module window_median_filter #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_RADIUS = 2
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wmf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	wmf_stream_if.sink                          pixels,
	wmf_stream_if.source                        results
);
	import wmf_pkg::*;

	localparam int NCB   = 2 * MAX_RADIUS + 1;
	localparam int SLOTS = 2 * MAX_RADIUS + 2;
	localparam int N     = SLOTS * NCB;
	localparam int DEPTH = (MAX_COLS + NCB - 1) / NCB;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMW   = $clog2(NCB);
	localparam int SW    = $clog2(SLOTS);

	logic             accept;
	logic             is_flush;
	logic             wr_en;
	logic [SW-1:0]    wr_slot;
	logic [CMW-1:0]   wr_bank;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr [NCB];
	logic [SLOTS-1:0] slot_ok;
	logic [NCB-1:0]   col_ok;
	item_info_t       info;

	logic [PIX_W-1:0] bank_data [N];
	logic [N-1:0]     mask_c;

	logic             valid_s1;
	logic [N-1:0]     mask_s1;
	logic             frame_end_s1;
	logic             s2_ready;

	logic             med_valid;
	logic [PIX_W-1:0] med_value;
	logic             med_frame_end;

	assign pixels.ready = !valid_s1 || s2_ready;
	assign accept       = pixels.valid && pixels.ready;
	assign is_flush     = (pixels.data.action == ACT_FLUSH);

	wmf_ctrl #(
		.MAX_COLS   (MAX_COLS),
		.MAX_RADIUS (MAX_RADIUS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.is_flush    (is_flush),
		.wr_en       (wr_en),
		.wr_slot     (wr_slot),
		.wr_bank     (wr_bank),
		.wr_addr     (wr_addr),
		.rd_addr     (rd_addr),
		.slot_ok     (slot_ok),
		.col_ok      (col_ok),
		.info        (info)
	);

	// Line store: one bank per line slot and column residue, so a window reads each once.
	for (genvar s = 0; s < SLOTS; s++) begin : g_slot
		for (genvar m = 0; m < NCB; m++) begin : g_bank
			wmf_bank #(
				.DEPTH (DEPTH)
			) u_bank (
				.clk     (clk),
				.wr_en   (wr_en && (wr_slot == SW'(s)) && (wr_bank == CMW'(m))),
				.wr_addr (wr_addr),
				.wr_data (pixels.data.pixel_value),
				.rd_en   (accept),
				.rd_addr (rd_addr[m]),
				.rd_data (bank_data[s*NCB+m])
			);
			assign mask_c[s*NCB+m] = slot_ok[s] && col_ok[m];
		end
	end

	// First stage: window mask and result flags, aligned with the bank read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= info.emit;
		end else if (s2_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mask_s1      <= mask_c;
			frame_end_s1 <= info.frame_end;
		end
	end

	wmf_median #(
		.N (N)
	) u_median (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (valid_s1),
		.in_ready      (s2_ready),
		.in_vals       (bank_data),
		.in_mask       (mask_s1),
		.in_frame_end  (frame_end_s1),
		.out_valid     (med_valid),
		.out_ready     (results.ready),
		.out_median    (med_value),
		.out_frame_end (med_frame_end)
	);

	assign results.valid             = med_valid;
	assign results.data.median_value = med_value;
	assign results.data.frame_end    = med_frame_end;

endmodule

`default_nettype wire

### design/wmf_bank.sv
// One line store bank: simple dual-port RAM with registered read data.
// Uses wmf_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none

module wmf_bank #(
	parameter int DEPTH = 205,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [AW-1:0]             wr_addr,
	input  wire logic [wmf_pkg::PIX_W-1:0] wr_data,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_addr,
	output logic      [wmf_pkg::PIX_W-1:0] rd_data
);
	import wmf_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_q;

	// A read of the address being written returns the new sample.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### design/wmf_ctrl.sv
// Configuration registers, input and output position counters and window masks.
// Uses wmf_pkg and the assertion macros of window_median_filter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "window_median_filter_defines.svh"

module wmf_ctrl #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_RADIUS = 2,
	localparam int NCB = 2 * MAX_RADIUS + 1,
	localparam int SLOTS = 2 * MAX_RADIUS + 2,
	localparam int DEPTH = (MAX_COLS + NCB - 1) / NCB,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CMW = $clog2(NCB),
	localparam int SW = $clog2(SLOTS)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wmf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	input  wire logic                           accept,
	input  wire logic                           is_flush,
	output logic                                wr_en,
	output logic      [SW-1:0]                  wr_slot,
	output logic      [CMW-1:0]                 wr_bank,
	output logic      [AW-1:0]                  wr_addr,
	output logic      [AW-1:0]                  rd_addr [NCB],
	output logic      [SLOTS-1:0]               slot_ok,
	output logic      [NCB-1:0]                 col_ok,
	output wmf_pkg::item_info_t                 info
);
	import wmf_pkg::*;

	localparam int COLW = $clog2(MAX_COLS + 1);
	localparam int CW   = COLW + 1;
	localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RADW = $clog2(MAX_RADIUS + 1);

	logic [ROWS_CFG_W-1:0] frame_rows_q;
	logic [COLS_CFG_W-1:0] frame_cols_q;
	logic [RAD_CFG_W-1:0]  window_radius_q;

	logic [ROW_CNT_W-1:0] rows_eff;
	logic [COLW-1:0]      cols_eff;
	logic [RADW-1:0]      rad_eff;
	logic                 cfg_hit;

	logic [ROW_IDX_W-1:0] in_row_q, in_row_n, out_row_q, out_row_n;
	logic [CIW-1:0]       in_col_q, in_col_n, out_col_q, out_col_n;
	logic [AW-1:0]        in_cq_q, in_cq_n, out_cq_q, out_cq_n;
	logic [CMW-1:0]       in_cm_q, in_cm_n, out_cm_q, out_cm_n;
	logic [SW-1:0]        in_slot_q, in_slot_n, out_slot_q, out_slot_n;
	logic                 done_q, done_n;

	logic                 pix_wr;
	logic [ROW_CNT_W-1:0] need_row;
	logic [CW-1:0]        need_col;
	logic                 ready;
	logic                 emit;
	logic                 frame_last;

	// Clip the register values to their usable ranges.
	always_comb begin
		if (frame_rows_q == '0) begin
			rows_eff = ROW_CNT_W'(1);
		end else if (32'(frame_rows_q) > MAX_ROWS) begin
			rows_eff = ROW_CNT_W'(MAX_ROWS);
		end else begin
			rows_eff = ROW_CNT_W'(frame_rows_q);
		end
		if (frame_cols_q == '0) begin
			cols_eff = COLW'(1);
		end else if (32'(frame_cols_q) > MAX_COLS) begin
			cols_eff = COLW'(MAX_COLS);
		end else begin
			cols_eff = COLW'(frame_cols_q);
		end
		if (32'(window_radius_q) > MAX_RADIUS) begin
			rad_eff = RADW'(MAX_RADIUS);
		end else begin
			rad_eff = RADW'(window_radius_q);
		end
	end

	// Only writes to a listed register take effect and restart the frame.
	always_comb begin
		case (cfg_index)
			REG_FRAME_ROWS, REG_FRAME_COLS, REG_WINDOW_RADIUS: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
	end

	assign pix_wr = accept && !is_flush && !done_q;

	// Position update for one request: store a pixel if the frame still needs it, then emit if the window is complete.
	always_comb begin
		in_row_n   = in_row_q;
		in_col_n   = in_col_q;
		in_cq_n    = in_cq_q;
		in_cm_n    = in_cm_q;
		in_slot_n  = in_slot_q;
		done_n     = done_q;
		out_row_n  = out_row_q;
		out_col_n  = out_col_q;
		out_cq_n   = out_cq_q;
		out_cm_n   = out_cm_q;
		out_slot_n = out_slot_q;
		frame_last = 1'b0;

		if (pix_wr) begin
			if (CW'(in_col_q) + CW'(1) >= CW'(cols_eff)) begin
				in_col_n = '0;
				in_cq_n  = '0;
				in_cm_n  = '0;
				if (ROW_CNT_W'(in_row_q) + ROW_CNT_W'(1) >= rows_eff) begin
					in_row_n  = '0;
					in_slot_n = '0;
					done_n    = 1'b1;
				end else begin
					in_row_n  = in_row_q + ROW_IDX_W'(1);
					in_slot_n = (in_slot_q == SW'(SLOTS - 1)) ? '0 : in_slot_q + SW'(1);
				end
			end else begin
				in_col_n = in_col_q + CIW'(1);
				if (in_cm_q == CMW'(NCB - 1)) begin
					in_cm_n = '0;
					in_cq_n = in_cq_q + AW'(1);
				end else begin
					in_cm_n = in_cm_q + CMW'(1);
				end
			end
		end

		// The bottom-right pixel of the window must have arrived.
		need_row = ROW_CNT_W'(out_row_q) + ROW_CNT_W'(rad_eff);
		if (need_row > rows_eff - ROW_CNT_W'(1)) begin
			need_row = rows_eff - ROW_CNT_W'(1);
		end
		need_col = CW'(out_col_q) + CW'(rad_eff);
		if (need_col > CW'(cols_eff) - CW'(1)) begin
			need_col = CW'(cols_eff) - CW'(1);
		end
		ready = done_n || (ROW_CNT_W'(in_row_n) > need_row) ||
			((ROW_CNT_W'(in_row_n) == need_row) && (CW'(in_col_n) > need_col));
		emit = accept && ready;

		if (emit) begin
			if (CW'(out_col_q) + CW'(1) >= CW'(cols_eff)) begin
				out_col_n = '0;
				out_cq_n  = '0;
				out_cm_n  = '0;
				if (ROW_CNT_W'(out_row_q) + ROW_CNT_W'(1) >= rows_eff) begin
					// Last result of the frame: everything starts over.
					frame_last = 1'b1;
					out_row_n  = '0;
					out_slot_n = '0;
					in_row_n   = '0;
					in_col_n   = '0;
					in_cq_n    = '0;
					in_cm_n    = '0;
					in_slot_n  = '0;
					done_n     = 1'b0;
				end else begin
					out_row_n  = out_row_q + ROW_IDX_W'(1);
					out_slot_n = (out_slot_q == SW'(SLOTS - 1)) ? '0 : out_slot_q + SW'(1);
				end
			end else begin
				out_col_n = out_col_q + CIW'(1);
				if (out_cm_q == CMW'(NCB - 1)) begin
					out_cm_n = '0;
					out_cq_n = out_cq_q + AW'(1);
				end else begin
					out_cm_n = out_cm_q + CMW'(1);
				end
			end
		end
	end

	// Window rows by line slot: slot distance ahead of the center row or behind it.
	always_comb begin
		logic [SW:0] d;
		logic [SW:0] k;
		for (int s = 0; s < SLOTS; s++) begin
			d = (SW+1)'(s) + (SW+1)'(SLOTS) - (SW+1)'(out_slot_q);
			if (d >= (SW+1)'(SLOTS)) begin
				d = d - (SW+1)'(SLOTS);
			end
			k = (SW+1)'(SLOTS) - d;
			if (d <= (SW+1)'(MAX_RADIUS)) begin
				slot_ok[s] = (d <= (SW+1)'(rad_eff)) &&
					(ROW_CNT_W'(out_row_q) + ROW_CNT_W'(d) <= rows_eff - ROW_CNT_W'(1));
			end else if (d == (SW+1)'(MAX_RADIUS + 1)) begin
				// The spare slot holds the line being filled ahead of the window.
				slot_ok[s] = 1'b0;
			end else begin
				slot_ok[s] = (k <= (SW+1)'(rad_eff)) &&
					(ROW_CNT_W'(out_row_q) >= ROW_CNT_W'(k));
			end
		end
	end

	// Window columns by column bank, with the bank word that holds each column.
	always_comb begin
		logic [CMW:0] dm;
		logic [CMW:0] k;
		for (int m = 0; m < NCB; m++) begin
			dm = (CMW+1)'(m) + (CMW+1)'(NCB) - (CMW+1)'(out_cm_q);
			if (dm >= (CMW+1)'(NCB)) begin
				dm = dm - (CMW+1)'(NCB);
			end
			k = (CMW+1)'(NCB) - dm;
			if (dm <= (CMW+1)'(MAX_RADIUS)) begin
				col_ok[m] = (dm <= (CMW+1)'(rad_eff)) &&
					(CW'(out_col_q) + CW'(dm) <= CW'(cols_eff) - CW'(1));
				rd_addr[m] = (CMW'(m) < out_cm_q) ? out_cq_q + AW'(1) : out_cq_q;
			end else begin
				col_ok[m] = (k <= (CMW+1)'(rad_eff)) && (CW'(out_col_q) >= CW'(k));
				rd_addr[m] = (CMW'(m) > out_cm_q) ? out_cq_q - AW'(1) : out_cq_q;
			end
		end
	end

	assign wr_en          = pix_wr;
	assign wr_slot        = in_slot_q;
	assign wr_bank        = in_cm_q;
	assign wr_addr        = in_cq_q;
	assign info.emit      = emit;
	assign info.frame_end = frame_last;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q    <= ROWS_CFG_W'(1);
			frame_cols_q    <= COLS_CFG_W'(1);
			window_radius_q <= RAD_CFG_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_ROWS:    frame_rows_q <= cfg_wr_data[ROWS_CFG_W-1:0];
				REG_FRAME_COLS:    frame_cols_q <= cfg_wr_data[COLS_CFG_W-1:0];
				REG_WINDOW_RADIUS: window_radius_q <= cfg_wr_data[RAD_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Position counters; a register write aborts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_cq_q    <= '0;
			in_cm_q    <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_cq_q   <= '0;
			out_cm_q   <= '0;
			out_slot_q <= '0;
			done_q     <= 1'b0;
		end else if (cfg_wr_en && cfg_hit) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_cq_q    <= '0;
			in_cm_q    <= '0;
			in_slot_q  <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_cq_q   <= '0;
			out_cm_q   <= '0;
			out_slot_q <= '0;
			done_q     <= 1'b0;
		end else if (accept) begin
			in_row_q   <= in_row_n;
			in_col_q   <= in_col_n;
			in_cq_q    <= in_cq_n;
			in_cm_q    <= in_cm_n;
			in_slot_q  <= in_slot_n;
			out_row_q  <= out_row_n;
			out_col_q  <= out_col_n;
			out_cq_q   <= out_cq_n;
			out_cm_q   <= out_cm_n;
			out_slot_q <= out_slot_n;
			done_q     <= done_n;
		end
	end

	// The output position never runs ahead of the input position within a frame.
	`WMF_ASSERT(a_out_behind_in, !done_q,
		({out_row_q, out_col_q} <= {in_row_q, in_col_q}), "output position ahead of input")
	// Column counters stay inside the configured frame width.
	`WMF_ASSERT(a_cols_in_range, 1'b1,
		((CW'(in_col_q) < CW'(cols_eff)) && (CW'(out_col_q) < CW'(cols_eff))),
		"column counter outside frame")
	// A register write restarts the frame.
	`WMF_ASSERT_NXT(a_cfg_restart, (cfg_wr_en && cfg_hit),
		((in_row_q == '0) && (out_row_q == '0) && !done_q), "frame not restarted")

endmodule

`default_nettype wire

### design/wmf_median.sv
// Median selection over the masked window: rank compare stage, then select stage.
// Uses wmf_pkg and the assertion macros of window_median_filter_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "window_median_filter_defines.svh"

module wmf_median #(
	parameter int N = 30,
	localparam int RW = $clog2(N + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [wmf_pkg::PIX_W-1:0] in_vals [N],
	input  wire logic [N-1:0]              in_mask,
	input  wire logic                      in_frame_end,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [wmf_pkg::PIX_W-1:0] out_median,
	output logic                           out_frame_end
);
	import wmf_pkg::*;

	logic [N-1:0]     lt_c [N];
	logic [RW-1:0]    half_c;

	logic             valid_s2;
	logic [N-1:0]     lt_s2 [N];
	logic [PIX_W-1:0] vals_s2 [N];
	logic [N-1:0]     mask_s2;
	logic [RW-1:0]    half_s2;
	logic             frame_end_s2;

	logic [N-1:0]     sel_c;
	logic [PIX_W-1:0] median_c;

	logic             valid_q;
	logic [PIX_W-1:0] median_q;
	logic             frame_end_q;

	logic             s2_ready;
	logic             s3_ready;

	assign s3_ready = !valid_q || out_ready;
	assign s2_ready = !valid_s2 || s3_ready;
	assign in_ready = s2_ready;

	// Element j counts below element i if it is in the window and smaller, ties by index.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				lt_c[i][j] = in_mask[j] &&
					((in_vals[j] < in_vals[i]) || ((in_vals[j] == in_vals[i]) && (j < i)));
			end
		end
		half_c = RW'($countones(in_mask)) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s2_ready) begin
			lt_s2        <= lt_c;
			vals_s2      <= in_vals;
			mask_s2      <= in_mask;
			half_s2      <= half_c;
			frame_end_s2 <= in_frame_end;
		end
	end

	// The element whose rank is half the count is the median.
	always_comb begin
		median_c = '0;
		for (int i = 0; i < N; i++) begin
			sel_c[i] = mask_s2[i] && (RW'($countones(lt_s2[i])) == half_s2);
			median_c = median_c | (sel_c[i] ? vals_s2[i] : '0);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s3_ready) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && s3_ready) begin
			median_q    <= median_c;
			frame_end_q <= frame_end_s2;
		end
	end

	assign out_valid     = valid_q;
	assign out_median    = median_q;
	assign out_frame_end = frame_end_q;

	// The window center is always inside the image.
	`WMF_ASSERT(a_mask_nonempty, in_valid, (in_mask != '0), "empty window")
	// Ranks of the window elements form a permutation, so exactly one is picked.
	`WMF_ASSERT(a_one_selected, valid_s2, $onehot(sel_c), "median select not one-hot")
	// The wanted rank lies below the element count.
	`WMF_ASSERT(a_half_in_range, valid_s2,
		(RW'($countones(mask_s2)) > half_s2), "median rank out of range")

endmodule

`default_nettype wire

### bench/window_median_filter_tb.sv
// Self-checking bench for the streaming window median filter.
// It drives frames of pixels and flush requests, predicts every median and compares.
// Depends on wmf_pkg, wmf_stream_if and the window_median_filter RTL.
`timescale 1ns / 1ps

module window_median_filter_tb;
	import wmf_pkg::*;

	localparam int LINE_SLOTS = 6;
	localparam int LINE_COLS  = 1024;
	localparam int SETTLE_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

	wmf_stream_if #(.payload_t(pix_req_t)) pixels_if ();
	wmf_stream_if #(.payload_t(med_rsp_t)) results_if ();

	window_median_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.pixels(pixels_if.sink),
		.results(results_if.source)
	);

	// Shadow copy of the filter state.
	logic [PIX_W-1:0] line_mem [LINE_SLOTS*LINE_COLS];
	int unsigned in_row, in_col, out_row, out_col;
	bit frame_received;
	int unsigned rows_reg, cols_reg, radius_reg;

	med_rsp_t expected_medians [$];
	int mismatch_count = 0;
	int sent_count = 0;
	bit calm_mode = 1'b0;

	always #10 clk = ~clk;

	initial begin
		pixels_if.valid = 1'b0;
		pixels_if.data = '0;
		results_if.ready = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic int unsigned eff_rows();
		if (rows_reg == 0) return 1;
		return rows_reg > MAX_ROWS ? MAX_ROWS : rows_reg;
	endfunction

	function automatic int unsigned eff_cols();
		if (cols_reg == 0) return 1;
		return cols_reg > LINE_COLS ? LINE_COLS : cols_reg;
	endfunction

	function automatic int unsigned eff_radius();
		return radius_reg > 2 ? 2 : radius_reg;
	endfunction

	function automatic void clear_position();
		in_row = 0; in_col = 0; out_row = 0; out_col = 0;
		frame_received = 1'b0;
	endfunction

	// Sorted pick at index n/2 of the in-image window around the output position.
	function automatic logic [PIX_W-1:0] window_median(input int unsigned nrows,
		input int unsigned ncols, input int unsigned rad);
		logic [PIX_W-1:0] vals [25];
		logic [PIX_W-1:0] v;
		int n, i;
		int unsigned r0, r1, c0, c1;
		n = 0;
		r0 = out_row >= rad ? out_row - rad : 0;
		r1 = out_row + rad > nrows - 1 ? nrows - 1 : out_row + rad;
		c0 = out_col >= rad ? out_col - rad : 0;
		c1 = out_col + rad > ncols - 1 ? ncols - 1 : out_col + rad;
		for (int unsigned r = r0; r <= r1; r++) begin
			for (int unsigned c = c0; c <= c1; c++) begin
				v = line_mem[(r % LINE_SLOTS) * LINE_COLS + c];
				i = n;
				while (i > 0 && vals[i-1] > v) begin
					vals[i] = vals[i-1];
					i--;
				end
				vals[i] = v;
				n++;
			end
		end
		return vals[n/2];
	endfunction

	// Advance the shadow state by one accepted request and queue any median.
	function automatic void predict_median(input action_t act, input logic [PIX_W-1:0] pix);
		int unsigned nrows, ncols, rad, need_r, need_c;
		med_rsp_t rsp;
		bit ready_now;
		nrows = eff_rows();
		ncols = eff_cols();
		rad = eff_radius();
		if (act == ACT_PIXEL && !frame_received) begin
			line_mem[(in_row % LINE_SLOTS) * LINE_COLS + in_col] = pix;
			in_col++;
			if (in_col >= ncols) begin
				in_col = 0;
				in_row++;
				if (in_row >= nrows) begin
					in_row = 0;
					frame_received = 1'b1;
				end
			end
		end
		need_r = out_row + rad > nrows - 1 ? nrows - 1 : out_row + rad;
		need_c = out_col + rad > ncols - 1 ? ncols - 1 : out_col + rad;
		ready_now = frame_received || in_row > need_r || (in_row == need_r && in_col > need_c);
		if (!ready_now) return;
		rsp.median_value = window_median(nrows, ncols, rad);
		rsp.frame_end = 1'b0;
		out_col++;
		if (out_col >= ncols) begin
			out_col = 0;
			out_row++;
			if (out_row >= nrows) begin
				rsp.frame_end = 1'b1;
				clear_position();
			end
		end
		expected_medians = {expected_medians, rsp};
	endfunction

	// Result side: random stalls, then compare each accepted result.
	always @(posedge clk) begin
		med_rsp_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_medians.size() == 0) begin
				report_mismatch("result with no pending expectation");
			end else begin
				want = expected_medians.pop_front();
				if (results_if.data.median_value !== want.median_value)
					report_mismatch($sformatf("median_value got %h want %h",
						results_if.data.median_value, want.median_value));
				if (results_if.data.frame_end !== want.frame_end)
					report_mismatch($sformatf("frame_end got %b want %b",
						results_if.data.frame_end, want.frame_end));
			end
		end
		results_if.ready <= calm_mode || ($urandom_range(99) >= 17);
	end

	// Send one request; valid stays high into the next request unless a gap is taken.
	task automatic send_request(input action_t act, input logic [PIX_W-1:0] pix);
		if (!calm_mode && $urandom_range(99) < 17) begin
			pixels_if.valid <= 1'b0;
			do @(posedge clk); while (!calm_mode && $urandom_range(99) < 17);
		end
		pixels_if.valid <= 1'b1;
		pixels_if.data <= '{action: act, pixel_value: pix};
		do @(posedge clk); while (!pixels_if.ready);
		predict_median(act, pix);
		sent_count++;
	endtask

	// Let every pending result arrive, then let the pipeline settle.
	task automatic wait_idle();
		int guard;
		pixels_if.valid <= 1'b0;
		guard = 0;
		while (expected_medians.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the enable drops again before the next write.
	task automatic write_register(input cfg_reg_t idx, input int unsigned val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FRAME_ROWS: rows_reg = val & 16'h1FFF;
			REG_FRAME_COLS: cols_reg = val & 16'h7FF;
			default: radius_reg = val & 3;
		endcase
		clear_position();
	endtask

	task automatic setup_frame(input int unsigned r, input int unsigned c, input int unsigned rad);
		wait_idle();
		write_register(REG_FRAME_ROWS, r);
		write_register(REG_FRAME_COLS, c);
		write_register(REG_WINDOW_RADIUS, rad);
	endtask

	// One whole frame of random pixels with random flushes mixed in, then drain by flushes or dropped pixels.
	task automatic run_frame(input int flush_pct, input bit drain_with_pixels);
		int unsigned total;
		total = eff_rows() * eff_cols();
		for (int unsigned k = 0; k < total; k++) begin
			if ($urandom_range(99) < flush_pct)
				send_request(ACT_FLUSH, 16'($urandom()));
			send_request(ACT_PIXEL, 16'($urandom()));
		end
		while (frame_received) begin
			if (drain_with_pixels) send_request(ACT_PIXEL, 16'($urandom()));
			else send_request(ACT_FLUSH, 16'($urandom()));
		end
	endtask

	// Reset values, full-scale samples and flushes with nothing ready.
	task automatic test_reset_defaults();
		send_request(ACT_PIXEL, 16'hFFFF);
		send_request(ACT_PIXEL, 16'h0000);
		send_request(ACT_FLUSH, 16'hFFFF);
		send_request(ACT_FLUSH, 16'h0000);
	endtask

	// Radius zero passes samples through; radius 3 acts as the largest radius.
	task automatic test_radius_extremes();
		setup_frame(2, 3, 0);
		send_request(ACT_PIXEL, 16'hFFFF);
		send_request(ACT_PIXEL, 16'h0000);
		send_request(ACT_PIXEL, 16'h8000);
		send_request(ACT_PIXEL, 16'h7FFF);
		send_request(ACT_PIXEL, 16'h0001);
		send_request(ACT_PIXEL, 16'hFFFE);
		setup_frame(4, 5, 3);
		run_frame(0, 1'b0);
	endtask

	// Shrinking windows at the borders, with pixels dropped after a finished frame.
	task automatic test_border_windows();
		setup_frame(5, 6, 2);
		run_frame(10, 1'b1);
		setup_frame(3, 3, 1);
		run_frame(30, 1'b0);
	endtask

	// Out-of-range register values clamp to the legal ends; the tall frame is cut short.
	task automatic test_register_clamps();
		setup_frame(0, 0, 2);
		run_frame(0, 1'b0);
		setup_frame(8191, 1, 1);
		for (int k = 0; k < 40; k++) send_request(ACT_PIXEL, 16'($urandom()));
		setup_frame(1, 2047, 2);
		run_frame(0, 1'b0);
	endtask

	// A register write part way through a frame abandons it.
	task automatic test_frame_abort();
		setup_frame(4, 4, 1);
		for (int k = 0; k < 7; k++) send_request(ACT_PIXEL, 16'($urandom()));
		setup_frame(3, 4, 2);
		run_frame(0, 1'b0);
	endtask

	// Random frame shapes and contents, a few broken off part way.
	task automatic test_random_frames();
		int unsigned part;
		while (sent_count < 1750) begin
			calm_mode = (sent_count > 1300 && sent_count < 1550);
			setup_frame($urandom_range(8, 1), $urandom_range(12, 1), $urandom_range(3));
			if ($urandom_range(9) == 0) begin
				part = $urandom_range(eff_rows() * eff_cols() - 1);
				for (int unsigned k = 0; k < part; k++) begin
					if ($urandom_range(99) < 15) send_request(ACT_FLUSH, 16'($urandom()));
					else send_request(ACT_PIXEL, 16'($urandom()));
				end
			end else begin
				run_frame($urandom_range(20), $urandom_range(1));
			end
		end
		calm_mode = 1'b0;
	endtask

	initial begin
		rows_reg = 1; cols_reg = 1; radius_reg = 1;
		clear_position();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_radius_extremes();
		test_border_windows();
		test_register_clamps();
		test_frame_abort();
		test_random_frames();
		wait_idle();
		if (mismatch_count == 0 && expected_medians.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (expected_medians.size() != 0)
				report_mismatch($sformatf("%0d expected results never arrived",
					expected_medians.size()));
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/wmf_pkg.sv
design/wmf_stream_if.sv
design/wmf_bank.sv
design/wmf_ctrl.sv
design/wmf_median.sv
design/window_median_filter.sv
bench/window_median_filter_tb.sv
